// ===== sv/ogl_pkg.sv =====
// Shared types, constants and helpers of the occupancy block grid labeler.
package ogl_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_BLOCK  = 64;

    localparam int PIX_W  = 8;
    localparam int BS_W   = 7;
    localparam int DIM_W  = 11;
    localparam int POS_W  = 10;
    localparam int IB_W   = 6;
    localparam int ID_W   = 21;
    localparam int FC_W   = 20;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int IDX_W  = 2;

    localparam int OUT_FIELDS_W = POS_W + POS_W + ID_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [BS_W-1:0]  BLOCK_RESET  = BS_W'(8);
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1024);

    typedef enum logic [IDX_W-1:0] {
        REG_BLOCK_SIZE   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } reg_index_t;

    // Everything the cell stage needs to know about one pixel.
    typedef struct packed {
        logic              black;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic              valid_cell;
        logic              seg_first;
        logic              seg_last;
        logic              first_row;
        logic              emit;
        logic              last_cell;
        logic              img_end;
    } pix_info_t;

    function automatic logic [BS_W-1:0] clamp_block(input logic [BS_W-1:0] v);
        logic [BS_W-1:0] r;
        if (v == '0)
            r = BS_W'(1);
        else if (v > BS_W'(MAX_BLOCK))
            r = BS_W'(MAX_BLOCK);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== sv/ogl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ogl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== sv/ogl_scan.sv =====
// Configuration registers and raster position counters of the labeler.
module ogl_scan import ogl_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    input  logic             accept,
    input  logic [PIX_W-1:0] pixel,
    output pix_info_t        info,
    output logic             restart
);

    logic [BS_W-1:0]  bs_reg, bs_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [POS_W-1:0] pc_reg, pc_next, pr_reg, pr_next;
    logic [IB_W-1:0]  cib_reg, cib_next, rib_reg, rib_next;
    logic [POS_W-1:0] bc_reg, bc_next, br_reg, br_next;
    // Pixel column / row just past the current cell; replaces a division by the block size.
    logic [DIM_W-1:0] col_end_reg, col_end_next, row_end_reg, row_end_next;

    logic [DIM_W-1:0] pc_inc, pr_inc;
    logic [BS_W-1:0]  cib_inc, rib_inc, bs_m1;
    logic [DIM_W:0]   col_far, row_far;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        bs_next     = bs_reg;
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE:
                begin
                    bs_next = clamp_block(cfg_data[BS_W-1:0]);
                    restart = 1'b1;
                end
                REG_IMAGE_WIDTH:
                begin
                    width_next = clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
                    restart     = 1'b1;
                end
                default:
                    restart = 1'b0;
            endcase
        end
    end

    assign pc_inc  = {1'b0, pc_reg} + DIM_W'(1);
    assign pr_inc  = {1'b0, pr_reg} + DIM_W'(1);
    assign cib_inc = {1'b0, cib_reg} + BS_W'(1);
    assign rib_inc = {1'b0, rib_reg} + BS_W'(1);
    assign bs_m1   = bs_reg - BS_W'(1);

    always_comb
    begin
        pc_next      = pc_reg;
        pr_next      = pr_reg;
        cib_next     = cib_reg;
        rib_next     = rib_reg;
        bc_next      = bc_reg;
        br_next      = br_reg;
        col_end_next = col_end_reg;
        row_end_next = row_end_reg;
        if (restart)
        begin
            pc_next      = '0;
            pr_next      = '0;
            cib_next     = '0;
            rib_next     = '0;
            bc_next      = '0;
            br_next      = '0;
            col_end_next = DIM_W'(bs_next);
            row_end_next = DIM_W'(bs_next);
        end
        else if (accept)
        begin
            if (cib_inc >= bs_reg)
            begin
                cib_next     = '0;
                bc_next      = bc_reg + POS_W'(1);
                col_end_next = col_end_reg + DIM_W'(bs_reg);
            end
            else
                cib_next = cib_inc[IB_W-1:0];

            if (pc_inc >= width_reg)
            begin
                pc_next      = '0;
                cib_next     = '0;
                bc_next      = '0;
                col_end_next = DIM_W'(bs_reg);
                if (rib_inc >= bs_reg)
                begin
                    rib_next     = '0;
                    br_next      = br_reg + POS_W'(1);
                    row_end_next = row_end_reg + DIM_W'(bs_reg);
                end
                else
                    rib_next = rib_inc[IB_W-1:0];
                if (pr_inc >= height_reg)
                begin
                    pr_next      = '0;
                    rib_next     = '0;
                    br_next      = '0;
                    row_end_next = DIM_W'(bs_reg);
                end
                else
                    pr_next = pr_inc[POS_W-1:0];
            end
            else
                pc_next = pc_inc[POS_W-1:0];
        end
    end

    assign col_far = {1'b0, col_end_reg} + (DIM_W+1)'(bs_reg);
    assign row_far = {1'b0, row_end_reg} + (DIM_W+1)'(bs_reg);

    always_comb
    begin
        info.black      = (pixel == '0);
        info.col        = bc_reg;
        info.row        = br_reg;
        info.valid_cell = (col_end_reg <= width_reg) && (row_end_reg <= height_reg);
        info.seg_first  = (cib_reg == '0);
        info.seg_last   = ({1'b0, cib_reg} == bs_m1);
        info.first_row  = (rib_reg == '0);
        info.emit       = info.valid_cell && info.seg_last && ({1'b0, rib_reg} == bs_m1);
        info.last_cell  = (col_far > {1'b0, width_reg}) && (row_far > {1'b0, height_reg});
        info.img_end    = (pc_inc >= width_reg) && (pr_inc >= height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg      <= BLOCK_RESET;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            pc_reg      <= '0;
            pr_reg      <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
            bc_reg      <= '0;
            br_reg      <= '0;
            col_end_reg <= DIM_W'(BLOCK_RESET);
            row_end_reg <= DIM_W'(BLOCK_RESET);
        end
        else
        begin
            bs_reg      <= bs_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            pc_reg      <= pc_next;
            pr_reg      <= pr_next;
            cib_reg     <= cib_next;
            rib_reg     <= rib_next;
            bc_reg      <= bc_next;
            br_reg      <= br_next;
            col_end_reg <= col_end_next;
            row_end_reg <= row_end_next;
        end
    end

endmodule

// ===== sv/ogl_cell.sv =====
// Pixel stage: merges the obstacle flag of each cell and builds the result word.
module ogl_cell import ogl_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  pix_info_t         info,
    input  logic              restart,
    output logic              take,
    output logic              flag_we,
    output logic [ADDR_W-1:0] flag_waddr,
    output logic              flag_wdata,
    input  logic              flag_rdata,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [POS_W-1:0]  cell_row,
    output logic [POS_W-1:0]  cell_col,
    output logic              occupied,
    output logic [ID_W-1:0]   free_id,
    output logic              last_cell
);

    pix_info_t        s1_reg;
    logic             s1_valid_reg;
    logic             fwd_hit_reg, fwd_data_reg;
    logic             acc_reg;
    logic [FC_W-1:0]  fc_reg;
    logic             out_valid_reg;
    logic [POS_W-1:0] row_reg, col_reg;
    logic             occ_reg, last_reg;
    logic [ID_W-1:0]  id_reg;

    logic s1_adv, prev_flag, merged;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || out_ready);
    assign take   = !s1_valid_reg || s1_adv;

    // The previous row's flag may be written in the same cycle it is read.
    assign prev_flag = fwd_hit_reg ? fwd_data_reg : flag_rdata;

    always_comb
    begin
        if (!s1_reg.seg_first)
            merged = s1_reg.black | acc_reg;
        else if (s1_reg.first_row)
            merged = s1_reg.black;
        else
            merged = s1_reg.black | prev_flag;
    end

    assign flag_we    = s1_adv && s1_reg.valid_cell && s1_reg.seg_last;
    assign flag_waddr = ADDR_W'(s1_reg.col);
    assign flag_wdata = merged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fc_reg        <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv && s1_reg.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (restart)
                fc_reg <= '0;
            else if (s1_adv)
            begin
                if (s1_reg.img_end)
                    fc_reg <= '0;
                else if (s1_reg.emit && !merged)
                    fc_reg <= fc_reg + FC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= info;
            fwd_hit_reg  <= flag_we && (flag_waddr == ADDR_W'(info.col));
            fwd_data_reg <= merged;
        end
        if (s1_adv)
            acc_reg <= merged;
        if (s1_adv && s1_reg.emit)
        begin
            row_reg  <= s1_reg.row;
            col_reg  <= s1_reg.col;
            occ_reg  <= merged;
            last_reg <= s1_reg.last_cell;
            id_reg   <= merged ? '1 : {1'b0, fc_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_row  = row_reg;
    assign cell_col  = col_reg;
    assign occupied  = occ_reg;
    assign free_id   = id_reg;
    assign last_cell = last_reg;

endmodule

// ===== sv/occupancy_block_grid_labeler_top.sv =====
// The pixel that completes a cell passes the pixel stage register, then its result word is registered at the output.
// Throughput: one pixel per cycle while the result output is not stalled, set by the single
// pixel stage and the one-read, one-write flag RAM that holds one obstacle flag per cell column.
// Reset (rst_n, asynchronous, active low) sets block size 8 and a 1024 x 1024 image,
// clears all position counters and the free-cell counter; the flag RAM needs no clearing since each
// cell's flag is written at the end of its first row segment, and that row ignores the stored flag.
module occupancy_block_grid_labeler_top import ogl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,  // [7:0] pixel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [9:0] cell_row, [19:10] cell_col,
                                                 // [40:20] free_id, rest zero
    output logic                  m_axis_tuser,  // [0] occupied
    output logic                  m_axis_tlast,  // last_cell
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [DIM_W-1:0]      cfg_data
);

    pix_info_t         info;
    logic              restart, accept, take;
    logic              flag_we, flag_wdata, flag_rdata;
    logic [ADDR_W-1:0] flag_waddr;
    logic [POS_W-1:0]  cell_row, cell_col;
    logic [ID_W-1:0]   free_id;

    assign s_axis_tready = take;
    assign accept        = s_axis_tvalid && take;

    ogl_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel     (s_axis_tdata),
        .info      (info),
        .restart   (restart)
    );

    ogl_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_flags (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (accept),
        .raddr (ADDR_W'(info.col)),
        .rdata (flag_rdata)
    );

    ogl_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .info       (info),
        .restart    (restart),
        .take       (take),
        .flag_we    (flag_we),
        .flag_waddr (flag_waddr),
        .flag_wdata (flag_wdata),
        .flag_rdata (flag_rdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .occupied   (m_axis_tuser),
        .free_id    (free_id),
        .last_cell  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DATA_W'({free_id, cell_col, cell_row});

endmodule

// ===== sv/ogl_checker.sv =====
// Port-level checks of the labeler, bound to the top level.
module ogl_checker import ogl_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);

    localparam int ID_LO = 2 * POS_W;

    // A word offered and not taken stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A stalled word keeps its contents.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // An occupied cell carries the all-ones free number.
    a_occ_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[ID_LO+ID_W-1:ID_LO] == '1)
        else $error("occupied cell without -1 free number");

    // A free cell has a non-negative number, and the padding stays zero.
    a_free_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            !m_axis_tdata[ID_LO+ID_W-1] && m_axis_tdata[OUT_DATA_W-1:OUT_FIELDS_W] == '0)
        else $error("free cell with negative number or dirty padding");

endmodule

bind occupancy_block_grid_labeler_top ogl_checker u_ogl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_occupancy_block_grid_labeler_top.sv =====
// Self-checking testbench for the occupancy block grid labeler: pixel streams against a cell predictor.
module tb_occupancy_block_grid_labeler_top;
    import ogl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int LATENCY_SLACK  = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RESET_PIXELS   = 16;
    localparam int SAT_PIXELS     = 64;
    localparam int RANDOM_PIXELS  = 884;

    // The index after the last register; a write there must change nothing.
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [POS_W-1:0] cell_row;
        logic [POS_W-1:0] cell_col;
        logic             occupied;
        logic [ID_W-1:0]  free_id;
        logic             last_cell;
    } cell_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index     = '0;
    logic [DIM_W-1:0]      cfg_data      = '0;

    // Settings of the labeler as the predictor sees them.
    int unsigned      blk_side;
    int unsigned      img_w;
    int unsigned      img_h;
    // Scan position within the current image.
    int unsigned      px_col;
    int unsigned      px_row;
    int unsigned      sub_col;
    int unsigned      sub_row;
    int unsigned      cell_c;
    int unsigned      cell_r;
    logic             cell_dark [MAX_WIDTH];
    logic [FC_W-1:0]  next_free;

    cell_result_t     cell_expect_q[$];
    int unsigned      pixels_sent    = 0;
    int unsigned      mismatches     = 0;
    int unsigned      quiet_cycles   = 0;
    int unsigned      src_idle_pct   = 0;
    int unsigned      sink_stall_pct = 0;

    occupancy_block_grid_labeler_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned saturate(input int unsigned v, input int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic void restart_image();
        px_col    = 0;
        px_row    = 0;
        sub_col   = 0;
        sub_row   = 0;
        cell_c    = 0;
        cell_r    = 0;
        next_free = '0;
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] value);
        bit known;
        known = 1'b1;
        case (idx)
            REG_BLOCK_SIZE:   blk_side = saturate(value[BS_W-1:0], MAX_BLOCK);
            REG_IMAGE_WIDTH:  img_w    = saturate(value, MAX_WIDTH);
            REG_IMAGE_HEIGHT: img_h    = saturate(value, MAX_HEIGHT);
            default:          known    = 1'b0;
        endcase
        if (known)
            restart_image();
    endfunction

    // Advances the scan by one pixel and queues the cell word it completes, if any.
    task automatic predict_pixel(input logic [PIX_W-1:0] pix);
        int unsigned  cols;
        int unsigned  rows;
        logic         dark;
        cell_result_t res;
        cols = img_w / blk_side;
        rows = img_h / blk_side;
        dark = (pix == '0);
        if (cell_c < cols && cell_r < rows)
        begin
            if (sub_col == 0 && sub_row == 0)
                cell_dark[cell_c] = dark;
            else if (dark)
                cell_dark[cell_c] = 1'b1;
            if (sub_col == blk_side - 1 && sub_row == blk_side - 1)
            begin
                res.cell_row  = POS_W'(cell_r);
                res.cell_col  = POS_W'(cell_c);
                res.occupied  = cell_dark[cell_c];
                res.last_cell = (cell_r == rows - 1) && (cell_c == cols - 1);
                if (res.occupied)
                    res.free_id = '1;
                else
                begin
                    res.free_id = {1'b0, next_free};
                    next_free   = next_free + 1'b1;
                end
                cell_expect_q.insert(cell_expect_q.size(), res);
            end
        end
        sub_col++;
        if (sub_col >= blk_side)
        begin
            sub_col = 0;
            cell_c++;
        end
        px_col++;
        if (px_col >= img_w)
        begin
            px_col  = 0;
            sub_col = 0;
            cell_c  = 0;
            sub_row++;
            if (sub_row >= blk_side)
            begin
                sub_row = 0;
                cell_r++;
            end
            px_row++;
            if (px_row >= img_h)
                restart_image();
        end
    endtask

    // A zero chance of one in one_in; one_in of zero means never black.
    function automatic logic [PIX_W-1:0] rand_pixel(input int unsigned one_in);
        if (one_in != 0 && $urandom_range(one_in - 1) == 0)
            return '0;
        return PIX_W'($urandom_range(1, 255));
    endfunction

    function automatic int unsigned rand_zero_odds();
        case ($urandom_range(4))
            0:       return 1;
            1:       return 2;
            2:       return 8;
            3:       return 64;
            default: return 0;
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_pixel(pix);
        pixels_sent++;
    endtask

    // With hold set, cfg_valid stays high for a write that follows at once.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] value,
                             input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (!hold)
            cfg_valid <= 1'b0;
        apply_reg(idx, value);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (cell_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // A pixel that completes no cell may still be in flight, so allow for the pipeline.
    task automatic settle();
        drain_results();
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_sink
        cell_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cell_expect_q.size() == 0)
            begin
                $error("cell word with nothing expected: row %0d col %0d",
                       m_axis_tdata[9:0], m_axis_tdata[19:10]);
                mismatches++;
            end
            else
            begin
                want = cell_expect_q.pop_front();
                check_field("cell_row", want.cell_row, m_axis_tdata[9:0]);
                check_field("cell_col", want.cell_col, m_axis_tdata[19:10]);
                check_field("free_id", want.free_id, m_axis_tdata[40:20]);
                check_field("tdata padding", 0, m_axis_tdata[OUT_DATA_W-1:41]);
                check_field("occupied", want.occupied, m_axis_tuser);
                check_field("last_cell", want.last_cell, m_axis_tlast);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Reset settings: 8 x 8 cells over a 1024-pixel row, so no cell completes
    // anywhere in the first row.
    task automatic test_reset_defaults();
        for (int i = 0; i < RESET_PIXELS; i++)
            send_pixel(rand_pixel(64));
    endtask

    task automatic test_corner_cases();
        settle();
        write_reg(REG_BLOCK_SIZE, {4'b1010, 7'd1}, 1'b1);
        write_reg(REG_IMAGE_WIDTH, DIM_W'(3), 1'b1);
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(2), 1'b0);
        // One cell per pixel; the sixth closes the image and numbering starts over.
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd128);
        send_pixel(8'd0);
        send_pixel(8'd254);
        send_pixel(8'd85);
        send_pixel(8'd170);
        // A write to the unused index must not restart the image.
        drain_results();
        write_reg(REG_UNUSED, '1, 1'b0);
        send_pixel(8'd0);
        settle();

        // A write in the middle of an image restarts it; the right column and
        // the bottom row form only partial cells, so a zero there changes nothing.
        write_reg(REG_BLOCK_SIZE, DIM_W'(2), 1'b1);
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(3), 1'b0);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_pixel((r == 2 || c == 2) ? 8'd0 : 8'd9);
        settle();

        // Block size saturates at 64 and exceeds the image: no cell ever completes.
        write_reg(REG_BLOCK_SIZE, '1, 1'b1);
        write_reg(REG_IMAGE_WIDTH, DIM_W'(2), 1'b1);
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(1), 1'b0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        settle();

        // Zero values act as one: every pixel is a whole one-cell image.
        write_reg(REG_BLOCK_SIZE, '0, 1'b1);
        write_reg(REG_IMAGE_WIDTH, '0, 1'b1);
        write_reg(REG_IMAGE_HEIGHT, '0, 1'b0);
        send_pixel(8'd200);
        send_pixel(8'd0);
    endtask

    task automatic test_register_saturation();
        settle();
        write_reg(REG_BLOCK_SIZE, DIM_W'(1), 1'b1);
        write_reg(REG_IMAGE_WIDTH, DIM_W'(1), 1'b1);
        write_reg(REG_IMAGE_HEIGHT, '1, 1'b0);
        for (int i = 0; i < SAT_PIXELS; i++)
            send_pixel(rand_pixel(8));
        settle();
        write_reg(REG_IMAGE_WIDTH, '1, 1'b1);
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(1), 1'b0);
        for (int i = 0; i < SAT_PIXELS; i++)
            send_pixel(rand_pixel(8));
    endtask

    task automatic test_random_images(input int unsigned src_pct, input int unsigned sink_pct,
                                      input int unsigned quota);
        logic [IDX_W-1:0] idx_list [4];
        logic [DIM_W-1:0] data_list [4];
        int unsigned      n_writes;
        logic [2:0]       mask;
        int unsigned      start;
        int unsigned      len;
        int unsigned      pause_at;
        int unsigned      odds;
        bit               first;
        bit               cut;
        logic [BS_W-1:0]  side;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start          = pixels_sent;
        first          = 1'b1;
        while (pixels_sent - start < quota)
        begin
            settle();
            n_writes = 0;
            if ($urandom_range(5) == 0)
            begin
                idx_list[n_writes]  = REG_UNUSED;
                data_list[n_writes] = DIM_W'($urandom);
                n_writes++;
            end
            mask  = first ? 3'b111 : 3'($urandom_range(1, 7));
            first = 1'b0;
            if (mask[0])
            begin
                case ($urandom_range(9))
                    0:       side = '0;
                    1:       side = BS_W'($urandom_range(MAX_BLOCK, 127));
                    default: side = BS_W'($urandom_range(1, 6));
                endcase
                idx_list[n_writes]  = REG_BLOCK_SIZE;
                data_list[n_writes] = {4'($urandom), side};
                n_writes++;
            end
            if (mask[1])
            begin
                idx_list[n_writes]  = REG_IMAGE_WIDTH;
                data_list[n_writes] = ($urandom_range(9) == 0) ? '0
                                                               : DIM_W'($urandom_range(1, 32));
                n_writes++;
            end
            if (mask[2])
            begin
                idx_list[n_writes]  = REG_IMAGE_HEIGHT;
                data_list[n_writes] = ($urandom_range(9) == 0) ? '0
                                                               : DIM_W'($urandom_range(1, 16));
                n_writes++;
            end
            for (int i = 0; i < n_writes; i++)
                write_reg(idx_list[i], data_list[i], i != n_writes - 1);

            for (int img = $urandom_range(1, 2); img > 0; img--)
            begin
                len      = img_w * img_h;
                cut      = ($urandom_range(7) == 0);
                if (cut)
                    len = $urandom_range(1, len);
                pause_at = ($urandom_range(7) == 0) ? $urandom_range(len - 1) : len;
                odds     = rand_zero_odds();
                // The phase stops at its pixel quota, even in the middle of an image.
                for (int p = 0; p < len && pixels_sent - start < quota; p++)
                begin
                    if (p == pause_at)
                        drain_results();
                    send_pixel(rand_pixel(odds));
                end
                // A broken-off image is left behind; the next register write restarts.
                if (cut)
                    break;
            end
        end
    endtask

    initial
    begin
        blk_side = BLOCK_RESET;
        img_w    = WIDTH_RESET;
        img_h    = HEIGHT_RESET;
        restart_image();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_corner_cases();
        test_register_saturation();
        test_random_images(0, 0, RANDOM_PIXELS / 4);
        test_random_images(77, 0, RANDOM_PIXELS / 4);
        test_random_images(0, 77, RANDOM_PIXELS / 4);
        test_random_images(7, 7, RANDOM_PIXELS / 4);
        settle();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ogl_pkg.sv
sv/ogl_ram.sv
sv/ogl_scan.sv
sv/ogl_cell.sv
sv/occupancy_block_grid_labeler_top.sv
sv/ogl_checker.sv
tb/tb_occupancy_block_grid_labeler_top.sv
